// ----- hdl/pth_pkg.sv -----
// Package for the pressure/temperature/humidity compensation block.
// Holds the item, result, trim and status types, constants and shift helpers.
// Used by every module under hdl except pth_div.
`default_nettype none
package pth_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int MUL_DIGITS  = 4;

    localparam logic [2:0] CFG_TEMP    = 3'd0;
    localparam logic [2:0] CFG_PRESS_A = 3'd1;
    localparam logic [2:0] CFG_PRESS_B = 3'd2;
    localparam logic [2:0] CFG_PRESS_C = 3'd3;
    localparam logic [2:0] CFG_HUM     = 3'd4;

    localparam logic [63:0] PR_OFFSET = 64'd128000;
    localparam logic [63:0] PR_BASE   = 64'd1048576;
    localparam logic [63:0] PR_SCALE  = 64'd3125;
    localparam logic [31:0] HU_OFFSET = 32'd76800;
    localparam logic [31:0] HU_CLAMP  = 32'd419430400;
    localparam logic [31:0] HU_BIAS   = 32'd2097152;

    typedef struct packed {
        logic [15:0] hum;
        logic [19:0] temp;
        logic [19:0] press;
    } item_t;

    typedef struct packed {
        logic [16:0] hum;
        logic [31:0] press;
        logic [31:0] temp;
    } result_t;

    typedef struct packed {
        logic [47:0] temp_trim;
        logic [63:0] press_a;
        logic [63:0] press_b;
        logic [15:0] press_c;
        logic [63:0] hum_trim;
    } cfg_t;

    typedef struct packed {
        logic idle;
        logic mul_busy;
        logic div_busy;
    } status_t;

    function automatic logic [31:0] sra32(input logic [31:0] x, input logic [4:0] sh);
        sra32 = $signed(x) >>> sh;
    endfunction

    function automatic logic [63:0] sra64(input logic [63:0] x, input logic [5:0] sh);
        sra64 = $signed(x) >>> sh;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/pth_sensor_compensation.sv -----
// Usage: raw pressure/temperature/humidity samples arrive as s_ transfers and
// leave compensated as m_ transfers, one result per sample, in order.
// s_tdata: adc_press [19:0], adc_temp [39:20], adc_hum [55:40].
// m_tdata: temp_centi [31:0] signed, press_q24_8 [63:32], hum_q7_10 [80:64].
// Trim words go in through cfg_wr_en/cfg_index/cfg_wdata (0 temp, 1 press A,
// 2 press B, 3 press C, 4 hum; other indexes ignored); the user must write
// them only while the block is idle, which the block itself does not enforce.
// Up to twenty-one multiplies run over one shared 64x16 multiplier, and a
// bit-serial divider forms the pressure quotient; a zero divisor skips the
// multiply that feeds the division, the division and the three multiplies
// after it. The sequencer takes a new sample only once the last result is in
// the output register; a four-entry input queue keeps accepting samples
// while the sequencer works.
// A finished result waits in the output register while m_tready is low; the
// sequencer stops before loading the next one, and the queue fills up.
// Reset (aresetn low, synchronous) empties the queue, idles the sequencer,
// drops any pending result and clears the trim registers to zero.
`default_nettype none
module pth_sensor_compensation #(
    parameter int QUEUE_DEPTH = pth_pkg::QUEUE_DEPTH
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [55:0] s_tdata,    // adc_press, adc_temp, adc_hum
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [87:0] m_tdata,    // temp_centi, press_q24_8, hum_q7_10, zero fill
    input  wire         cfg_wr_en,
    input  wire  [2:0]  cfg_index,
    input  wire  [63:0] cfg_wdata
);
    pth_pkg::cfg_t    cfg_reg;
    pth_pkg::item_t   q_item;
    pth_pkg::status_t status;
    logic             q_valid, q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pth_pkg::CFG_TEMP:    cfg_reg.temp_trim <= cfg_wdata[47:0];
                pth_pkg::CFG_PRESS_A: cfg_reg.press_a   <= cfg_wdata;
                pth_pkg::CFG_PRESS_B: cfg_reg.press_b   <= cfg_wdata;
                pth_pkg::CFG_PRESS_C: cfg_reg.press_c   <= cfg_wdata[15:0];
                pth_pkg::CFG_HUM:     cfg_reg.hum_trim  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    pth_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    pth_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .cfg      (cfg_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .status   (status)
    );

`ifndef SYNTHESIS
    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(status.mul_busy && status.div_busy))
        else $error("multiplier and divider busy together");

    a_pop_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready) |-> (status.idle && !status.mul_busy && !status.div_busy))
        else $error("queue popped while sequencer busy");

    a_full_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_valid)
        else $error("input stalled with empty queue");
`endif
endmodule
`default_nettype wire

// ----- hdl/pth_front.sv -----
// Front end: accepts raw sample transfers and holds them in a short queue.
// Depends on pth_pkg.
`default_nettype none
module pth_front #(
    parameter int DEPTH = pth_pkg::QUEUE_DEPTH
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [55:0]         s_tdata,   // adc_press[19:0], adc_temp[39:20], adc_hum[55:40]
    output logic                q_valid,
    input  wire                 q_ready,
    output pth_pkg::item_t      q_item
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pth_pkg::item_t  mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push, pop;

    assign s_tready = (count_reg != CW'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_tdata;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/pth_mul.sv -----
// Shared 64x64 multiplier, low 64 product bits, one 16-bit digit per cycle.
// Depends on pth_pkg.
`default_nettype none
module pth_mul (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         start,
    input  wire  [63:0] op_a,
    input  wire  [63:0] op_b,
    output logic        done,
    output logic        busy,
    output logic [63:0] prod
);
    localparam int DW = $clog2(pth_pkg::MUL_DIGITS);

    logic [63:0] a_reg, b_reg, acc_reg;
    logic [DW-1:0] cnt_reg;
    logic busy_reg, done_reg;
    logic [79:0] pp;
    logic [63:0] acc_next;

    assign pp       = a_reg * b_reg[15:0];
    assign acc_next = acc_reg + pp[63:0];
    assign done     = done_reg;
    assign busy     = busy_reg;
    assign prod     = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DW'(pth_pkg::MUL_DIGITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= op_a;
            b_reg   <= op_b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            a_reg   <= {a_reg[47:0], 16'b0};
            b_reg   <= {16'b0, b_reg[63:16]};
            acc_reg <= acc_next;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/pth_div.sv -----
// Signed 64-bit divider on magnitudes, restoring, one quotient bit per cycle.
// Depends on no package.
`default_nettype none
module pth_div (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         start,
    input  wire  [63:0] dividend_mag,
    input  wire  [63:0] divisor_mag,
    input  wire         negate,
    output logic        done,
    output logic        busy,
    output logic [63:0] quotient
);
    logic [63:0] rem_reg, quo_reg, dvs_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg, busy_reg, done_reg;
    logic [64:0] rem_sh, diff;
    logic        fits;

    assign rem_sh   = {rem_reg, quo_reg[63]};
    assign diff     = rem_sh - {1'b0, dvs_reg};
    assign fits     = !diff[64];
    assign done     = done_reg;
    assign busy     = busy_reg;
    assign quotient = neg_reg ? (64'd0 - quo_reg) : quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend_mag;
            dvs_reg <= divisor_mag;
            neg_reg <= negate;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[63:0] : rem_sh[63:0];
            quo_reg <= {quo_reg[62:0], fits};
        end
    end
endmodule
`default_nettype wire

// ----- hdl/pth_back.sv -----
// Back end: sequences the trim formulas over the shared multiplier and divider
// and holds the finished result in an output register. Depends on pth_pkg,
// pth_mul and pth_div.
`default_nettype none
module pth_back (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 q_valid,
    output logic                q_ready,
    input  pth_pkg::item_t      q_item,
    input  pth_pkg::cfg_t       cfg,
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [87:0]         m_tdata,
    output pth_pkg::status_t    status
);
    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_T0   = 5'd1;
    localparam logic [4:0] ST_T1   = 5'd2;
    localparam logic [4:0] ST_T2   = 5'd3;
    localparam logic [4:0] ST_P0   = 5'd4;
    localparam logic [4:0] ST_P1   = 5'd5;
    localparam logic [4:0] ST_P2   = 5'd6;
    localparam logic [4:0] ST_P3   = 5'd7;
    localparam logic [4:0] ST_P4   = 5'd8;
    localparam logic [4:0] ST_P5   = 5'd9;
    localparam logic [4:0] ST_P6   = 5'd10;
    localparam logic [4:0] ST_DIV  = 5'd11;
    localparam logic [4:0] ST_P7   = 5'd12;
    localparam logic [4:0] ST_P8   = 5'd13;
    localparam logic [4:0] ST_P9   = 5'd14;
    localparam logic [4:0] ST_H0   = 5'd15;
    localparam logic [4:0] ST_H1   = 5'd16;
    localparam logic [4:0] ST_H2   = 5'd17;
    localparam logic [4:0] ST_H3   = 5'd18;
    localparam logic [4:0] ST_H4   = 5'd19;
    localparam logic [4:0] ST_H5   = 5'd20;
    localparam logic [4:0] ST_H6   = 5'd21;
    localparam logic [4:0] ST_H7   = 5'd22;
    localparam logic [4:0] ST_OUT  = 5'd23;

    logic [4:0]  state_reg;
    logic        wait_reg;
    logic        out_valid_reg;
    pth_pkg::result_t out_reg;
    pth_pkg::item_t   item_reg;

    logic [31:0] ta_reg, ts_reg, tf_reg, press_reg, x_reg, ya_reg, yb_reg;
    logic [16:0] hum_reg;
    logic [63:0] sq_reg, v2_reg, w_reg, dvs_reg, pq_reg;

    logic        mul_start, mul_done, mul_busy;
    logic [63:0] mul_a, mul_b, mul_prod;
    logic [31:0] prod32;
    logic        div_start, div_done, div_busy;
    logic [63:0] div_num, div_den;
    logic        div_neg;
    logic [63:0] div_q;
    logic        mul_state, out_free;

    logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6, x0, dt, hvc, tf_next, temp_c;
    logic [31:0] hum_v, hum_c;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1c, p0, psum, dvs_next;
    logic [63:0] press_full;

    assign t1 = {16'b0, cfg.temp_trim[15:0]};
    assign t2 = {{16{cfg.temp_trim[31]}}, cfg.temp_trim[31:16]};
    assign t3 = {{16{cfg.temp_trim[47]}}, cfg.temp_trim[47:32]};
    assign p1 = {48'b0, cfg.press_a[15:0]};
    assign p2 = {{48{cfg.press_a[31]}}, cfg.press_a[31:16]};
    assign p3 = {{48{cfg.press_a[47]}}, cfg.press_a[47:32]};
    assign p4 = {{48{cfg.press_a[63]}}, cfg.press_a[63:48]};
    assign p5 = {{48{cfg.press_b[15]}}, cfg.press_b[15:0]};
    assign p6 = {{48{cfg.press_b[31]}}, cfg.press_b[31:16]};
    assign p7 = {{48{cfg.press_b[47]}}, cfg.press_b[47:32]};
    assign p8 = {{48{cfg.press_b[63]}}, cfg.press_b[63:48]};
    assign p9 = {{48{cfg.press_c[15]}}, cfg.press_c};
    assign h1 = {24'b0, cfg.hum_trim[7:0]};
    assign h2 = {{16{cfg.hum_trim[23]}}, cfg.hum_trim[23:8]};
    assign h3 = {24'b0, cfg.hum_trim[31:24]};
    assign h4 = {{20{cfg.hum_trim[43]}}, cfg.hum_trim[43:32]};
    assign h5 = {{20{cfg.hum_trim[55]}}, cfg.hum_trim[55:44]};
    assign h6 = {{24{cfg.hum_trim[63]}}, cfg.hum_trim[63:56]};

    assign prod32  = mul_prod[31:0];
    assign x0      = {15'b0, item_reg.temp[19:3]} - {t1[30:0], 1'b0};
    assign dt      = {16'b0, item_reg.temp[19:4]} - t1;
    assign v1c     = {{32{tf_reg[31]}}, tf_reg} - pth_pkg::PR_OFFSET;
    assign hvc     = tf_reg - pth_pkg::HU_OFFSET;
    assign p0      = pth_pkg::PR_BASE - {44'b0, item_reg.press};
    assign tf_next = ta_reg + pth_pkg::sra32(prod32, 5'd14);
    assign temp_c  = pth_pkg::sra32({tf_reg[29:0], 2'b0} + tf_reg + 32'd128, 5'd8);
    assign dvs_next = pth_pkg::sra64(mul_prod, 6'd33);
    assign psum    = pq_reg + v2_reg + pth_pkg::sra64(mul_prod, 6'd19);
    assign press_full = pth_pkg::sra64(psum, 6'd8) + (p7 << 4);
    assign hum_v   = yb_reg - pth_pkg::sra32(prod32, 5'd4);
    assign hum_c   = hum_v[31] ? 32'd0 :
                     (hum_v > pth_pkg::HU_CLAMP) ? pth_pkg::HU_CLAMP : hum_v;

    assign mul_state = (state_reg != ST_IDLE) && (state_reg != ST_DIV) &&
                       (state_reg != ST_OUT);
    assign mul_start = mul_state && !wait_reg;
    assign out_free  = !out_valid_reg || m_tready;
    assign q_ready   = (state_reg == ST_IDLE);

    assign div_start = (state_reg == ST_P6) && mul_done;
    assign div_num   = mul_prod[63] ? (64'd0 - mul_prod) : mul_prod;
    assign div_den   = dvs_reg[63] ? (64'd0 - dvs_reg) : dvs_reg;
    assign div_neg   = mul_prod[63] ^ dvs_reg[63];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_T0: begin mul_a = {32'b0, x0};     mul_b = {32'b0, t2}; end
            ST_T1: begin mul_a = {32'b0, dt};     mul_b = {32'b0, dt}; end
            ST_T2: begin mul_a = {32'b0, ts_reg}; mul_b = {32'b0, t3}; end
            ST_P0: begin mul_a = v1c;    mul_b = v1c; end
            ST_P1: begin mul_a = sq_reg; mul_b = p6;  end
            ST_P2: begin mul_a = v1c;    mul_b = p5;  end
            ST_P3: begin mul_a = sq_reg; mul_b = p3;  end
            ST_P4: begin mul_a = v1c;    mul_b = p2;  end
            ST_P5: begin mul_a = (64'd1 << 47) + w_reg; mul_b = p1; end
            ST_P6: begin mul_a = (p0 << 31) - v2_reg; mul_b = pth_pkg::PR_SCALE; end
            ST_P7: begin
                mul_a = pth_pkg::sra64(pq_reg, 6'd13);
                mul_b = pth_pkg::sra64(pq_reg, 6'd13);
            end
            ST_P8: begin mul_a = p9; mul_b = w_reg;  end
            ST_P9: begin mul_a = p8; mul_b = pq_reg; end
            ST_H0: begin mul_a = {32'b0, h5};     mul_b = {32'b0, hvc}; end
            ST_H1: begin mul_a = {32'b0, hvc};    mul_b = {32'b0, h6};  end
            ST_H2: begin mul_a = {32'b0, hvc};    mul_b = {32'b0, h3};  end
            ST_H3: begin mul_a = {32'b0, ya_reg}; mul_b = {32'b0, yb_reg}; end
            ST_H4: begin mul_a = {32'b0, ya_reg}; mul_b = {32'b0, h2};  end
            ST_H5: begin mul_a = {32'b0, x_reg};  mul_b = {32'b0, ya_reg}; end
            ST_H6: begin
                mul_a = {32'b0, pth_pkg::sra32(yb_reg, 5'd15)};
                mul_b = {32'b0, pth_pkg::sra32(yb_reg, 5'd15)};
            end
            ST_H7: begin mul_a = {32'b0, ya_reg}; mul_b = {32'b0, h1}; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    pth_mul u_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mul_start),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .done     (mul_done),
        .busy     (mul_busy),
        .prod     (mul_prod)
    );

    pth_div u_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (div_start),
        .dividend_mag (div_num),
        .divisor_mag  (div_den),
        .negate       (div_neg),
        .done         (div_done),
        .busy         (div_busy),
        .quotient     (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wait_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (mul_start) begin
                wait_reg <= 1'b1;
            end
            unique case (state_reg) inside
                ST_IDLE: begin
                    if (q_valid) begin
                        state_reg <= ST_T0;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_P7;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_P5: begin
                    if (mul_done) begin
                        wait_reg  <= 1'b0;
                        state_reg <= (dvs_next == 64'd0) ? ST_H0 : ST_P6;
                    end
                end
                ST_P6: begin
                    if (mul_done) begin
                        wait_reg  <= 1'b0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_P9: begin
                    if (mul_done) begin
                        wait_reg  <= 1'b0;
                        state_reg <= ST_H0;
                    end
                end
                ST_H7: begin
                    if (mul_done) begin
                        wait_reg  <= 1'b0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_T0, ST_T1, ST_T2, ST_P0, ST_P1, ST_P2, ST_P3, ST_P4,
                ST_P7, ST_P8, ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6: begin
                    if (mul_done) begin
                        wait_reg  <= 1'b0;
                        state_reg <= state_reg + 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && q_valid) begin
            item_reg <= q_item;
        end
        if (state_reg == ST_OUT && out_free) begin
            out_reg.temp  <= temp_c;
            out_reg.press <= press_reg;
            out_reg.hum   <= hum_reg;
        end
        if (state_reg == ST_DIV && div_done) begin
            pq_reg <= div_q;
        end
        if (mul_done) begin
            case (state_reg)
                ST_T0: ta_reg <= pth_pkg::sra32(prod32, 5'd11);
                ST_T1: ts_reg <= pth_pkg::sra32(prod32, 5'd12);
                ST_T2: tf_reg <= tf_next;
                ST_P0: sq_reg <= mul_prod;
                ST_P1: v2_reg <= mul_prod;
                ST_P2: v2_reg <= v2_reg + (mul_prod << 17) + (p4 << 35);
                ST_P3: w_reg  <= pth_pkg::sra64(mul_prod, 6'd8);
                ST_P4: w_reg  <= w_reg + (mul_prod << 12);
                ST_P5: begin
                    dvs_reg   <= dvs_next;
                    press_reg <= '0;
                end
                ST_P7: w_reg  <= mul_prod;
                ST_P8: v2_reg <= pth_pkg::sra64(mul_prod, 6'd25);
                ST_P9: press_reg <= press_full[31:0];
                ST_H0: x_reg  <= pth_pkg::sra32({2'b0, item_reg.hum, 14'b0} -
                                 {h4[11:0], 20'b0} - prod32 + 32'd16384, 5'd15);
                ST_H1: ya_reg <= pth_pkg::sra32(prod32, 5'd10);
                ST_H2: yb_reg <= pth_pkg::sra32(prod32, 5'd11) + 32'd32768;
                ST_H3: ya_reg <= pth_pkg::sra32(prod32, 5'd10) + pth_pkg::HU_BIAS;
                ST_H4: ya_reg <= pth_pkg::sra32(prod32 + 32'd8192, 5'd14);
                ST_H5: yb_reg <= prod32;
                ST_H6: ya_reg <= pth_pkg::sra32(prod32, 5'd7);
                ST_H7: hum_reg <= hum_c[28:12];
                default: ;
            endcase
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = {7'b0, out_reg};
    assign status.idle     = (state_reg == ST_IDLE);
    assign status.mul_busy = mul_busy;
    assign status.div_busy = div_busy;
endmodule
`default_nettype wire
